// ===== src/quadric_edge_collapse_cost_top_assert.svh =====
// Assertion macros for the edge collapse cost block
`ifndef QUADRIC_EDGE_COLLAPSE_COST_TOP_ASSERT_SVH
`define QUADRIC_EDGE_COLLAPSE_COST_TOP_ASSERT_SVH
// implication checked every clock, off while in reset
`define QEC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define QEC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/qecc_pkg.sv =====
`default_nettype none
package qecc_pkg;
  localparam int QW = 32;
  localparam int SW = 33;   // sum of two entries
  localparam int WW = 256;  // wide working word
  localparam int QDEPTH = 2;
  localparam int QAW = 1;

  typedef logic signed [QW-1:0] entry_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [WW-1:0] wide_t;

  // summed quadric travelling from front to back
  typedef struct packed {
    sum_t s00, s01, s02, s03, s11, s12, s13, s22, s23, s33;
  } quad_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DET, ST_DIVSET, ST_DIV, ST_DIVEND,
    ST_COST, ST_RND, ST_OUT
  } state_e;
endpackage
`default_nettype wire

// ===== src/qecc_front.sv =====
`default_nettype none
module qecc_front (
  input  wire logic                 clk_i,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire qecc_pkg::entry_t     q_i [10],
  input  wire logic                 is_second_i,
  output logic                      push_o,
  output qecc_pkg::quad_t           quad_o,
  input  wire logic                 full_i
);
  qecc_pkg::entry_t held_q [10];
  qecc_pkg::sum_t   s [10];

  // first item held, second stalls only when the queue is full
  assign in_ready = !full_i;
  assign push_o   = in_valid && !full_i && is_second_i;

  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready && !is_second_i) begin
      for (int k = 0; k < 10; k++) held_q[k] <= q_i[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      s[k] = qecc_pkg::SW'(held_q[k]) + qecc_pkg::SW'(q_i[k]);
    end
  end
  assign quad_o = '{s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7], s[8], s[9]};
endmodule
`default_nettype wire

// ===== src/qecc_queue.sv =====
`default_nettype none
module qecc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire qecc_pkg::quad_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output qecc_pkg::quad_t      data_o
);
  qecc_pkg::quad_t mem_q [qecc_pkg::QDEPTH];
  logic [qecc_pkg::QAW-1:0] wp_q, rp_q;
  logic [qecc_pkg::QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (qecc_pkg::QAW+1)'(qecc_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (qecc_pkg::QAW+1)'(push_i) - (qecc_pkg::QAW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== src/qecc_back.sv =====
`default_nettype none
module qecc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [62:0]      thr_i,
  input  wire logic             empty_i,
  input  wire qecc_pkg::quad_t  quad_i,
  output logic                  pop_o,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic signed [31:0]    pos_x_o,
  output logic signed [31:0]    pos_y_o,
  output logic signed [31:0]    pos_z_o,
  output logic signed [63:0]    cost_o,
  output logic                  singular_o
);
  // product schedule: 24 triple products, each +/-, accumulated into 4 sums
  // sel codes: 0 q00 1 q01 2 q02 3 q03 4 q11 5 q12 6 q13 7 q22 8 q23
  typedef struct packed {
    logic [3:0] a, b, c;
    logic       neg;
    logic [1:0] dst;
  } prod_t;
  function automatic prod_t ptab(input logic [4:0] i);
    case (i)
      5'd0:  ptab = '{4'd0, 4'd4, 4'd7, 1'b0, 2'd0};
      5'd1:  ptab = '{4'd2, 4'd2, 4'd4, 1'b1, 2'd0};
      5'd2:  ptab = '{4'd1, 4'd2, 4'd5, 1'b0, 2'd0};
      5'd3:  ptab = '{4'd1, 4'd2, 4'd5, 1'b0, 2'd0};
      5'd4:  ptab = '{4'd0, 4'd5, 4'd5, 1'b1, 2'd0};
      5'd5:  ptab = '{4'd1, 4'd1, 4'd7, 1'b1, 2'd0};
      5'd6:  ptab = '{4'd1, 4'd6, 4'd7, 1'b0, 2'd1};
      5'd7:  ptab = '{4'd2, 4'd5, 4'd6, 1'b1, 2'd1};
      5'd8:  ptab = '{4'd3, 4'd5, 4'd5, 1'b0, 2'd1};
      5'd9:  ptab = '{4'd3, 4'd4, 4'd7, 1'b1, 2'd1};
      5'd10: ptab = '{4'd2, 4'd4, 4'd8, 1'b0, 2'd1};
      5'd11: ptab = '{4'd1, 4'd5, 4'd8, 1'b1, 2'd1};
      5'd12: ptab = '{4'd2, 4'd2, 4'd6, 1'b0, 2'd2};
      5'd13: ptab = '{4'd1, 4'd3, 4'd7, 1'b0, 2'd2};
      5'd14: ptab = '{4'd0, 4'd6, 4'd7, 1'b1, 2'd2};
      5'd15: ptab = '{4'd0, 4'd5, 4'd8, 1'b0, 2'd2};
      5'd16: ptab = '{4'd2, 4'd3, 4'd5, 1'b1, 2'd2};
      5'd17: ptab = '{4'd2, 4'd1, 4'd8, 1'b1, 2'd2};
      5'd18: ptab = '{4'd2, 4'd3, 4'd4, 1'b0, 2'd3};
      5'd19: ptab = '{4'd1, 4'd3, 4'd5, 1'b1, 2'd3};
      5'd20: ptab = '{4'd1, 4'd2, 4'd6, 1'b1, 2'd3};
      5'd21: ptab = '{4'd0, 4'd5, 4'd6, 1'b0, 2'd3};
      5'd22: ptab = '{4'd1, 4'd1, 4'd8, 1'b0, 2'd3};
      5'd23: ptab = '{4'd0, 4'd4, 4'd8, 1'b1, 2'd3};
      default: ptab = '{4'd0, 4'd0, 4'd0, 1'b0, 2'd0};
    endcase
  endfunction

  qecc_pkg::state_e st_q, st_d;
  qecc_pkg::quad_t  qd_q;
  logic [4:0]  idx_q;
  logic [1:0]  ph_q;         // product phase: 0 a*b, 1 low half *c, 2 high half, 3 accumulate
  logic signed [65:0]  p1_q;
  logic signed [98:0]  p2_q;
  logic signed [qecc_pkg::WW-1:0] acc_q [4];
  logic [1:0]  ax_q;         // axis under division
  logic [7:0]  bit_q;
  logic [qecc_pkg::WW-1:0] num_q, den_q, rem_q, quo_q;
  logic        nneg_q;
  logic signed [31:0] v_q [3];
  logic [3:0]  ci_q;         // cost term index i*4+j
  logic signed [qecc_pkg::WW-1:0] cost_q;

  function automatic logic signed [32:0] sel(input qecc_pkg::quad_t q, input logic [3:0] s);
    case (s)
      4'd0: sel = q.s00; 4'd1: sel = q.s01; 4'd2: sel = q.s02; 4'd3: sel = q.s03;
      4'd4: sel = q.s11; 4'd5: sel = q.s12; 4'd6: sel = q.s13; 4'd7: sel = q.s22;
      4'd8: sel = q.s23; 4'd9: sel = q.s33; default: sel = '0;
    endcase
  endfunction
  // quadric element (i,j) for the cost
  function automatic logic signed [32:0] aij(input qecc_pkg::quad_t q, input logic [3:0] ij);
    logic [1:0] i, j, lo, hi;
    i = ij[3:2]; j = ij[1:0];
    lo = (i < j) ? i : j; hi = (i < j) ? j : i;
    case ({lo, hi})
      4'b0000: aij = q.s00; 4'b0001: aij = q.s01; 4'b0010: aij = q.s02;
      4'b0011: aij = q.s03; 4'b0101: aij = q.s11; 4'b0110: aij = q.s12;
      4'b0111: aij = q.s13; 4'b1010: aij = q.s22; 4'b1011: aij = q.s23;
      4'b1111: aij = q.s33; default: aij = '0;
    endcase
  endfunction

  prod_t pe;
  logic [qecc_pkg::WW-1:0] rem_sh;
  logic signed [qecc_pkg::WW-1:0] det_w, qs;
  logic        det_ok;
  logic signed [32:0] vi, vj;
  logic signed [qecc_pkg::WW-1:0] cost_r, cost_sat;
  logic        sat_hi, sat_lo;
  logic        in_cost;
  logic signed [32:0] ma, mb, mc;
  logic signed [65:0] m0;
  logic signed [33:0] plo;
  logic signed [32:0] phi;
  logic signed [66:0] mlo;
  logic signed [65:0] mhi;

  assign pe = ptab(idx_q);
  assign det_w = acc_q[0];
  assign det_ok = !det_w[qecc_pkg::WW-1] &&
                  (det_w > $signed({193'd0, thr_i}));
  assign rem_sh = {rem_q[qecc_pkg::WW-2:0], num_q[bit_q]};
  assign vi = (ci_q[3:2] == 2'd3) ? 33'sd65536 : 33'(v_q[ci_q[3:2]]);
  assign vj = (ci_q[1:0] == 2'd3) ? 33'sd65536 : 33'(v_q[ci_q[1:0]]);
  assign qs = nneg_q ? -$signed(quo_q) : $signed(quo_q);
  assign sat_hi = !qs[qecc_pkg::WW-1] && (qs[qecc_pkg::WW-1:31] != '0);
  assign sat_lo = qs[qecc_pkg::WW-1] && (qs[qecc_pkg::WW-1:31] != '1);
  assign cost_r = (cost_q + 256'sd32768) >>> 16;

  // shared multipliers: 33x33 first factor, then the 66-bit product by halves
  assign in_cost = (st_q == qecc_pkg::ST_COST);
  assign ma  = in_cost ? aij(qd_q, ci_q) : sel(qd_q, pe.a);
  assign mb  = in_cost ? vi : sel(qd_q, pe.b);
  assign mc  = in_cost ? vj : sel(qd_q, pe.c);
  assign m0  = ma * mb;
  assign plo = $signed({1'b0, p1_q[32:0]});
  assign phi = p1_q[65:33];
  assign mlo = plo * mc;
  assign mhi = phi * mc;

  assign pop_o = (st_q == qecc_pkg::ST_IDLE) && !empty_i;
  assign out_valid = (st_q == qecc_pkg::ST_OUT);

  always_comb begin
    st_d = st_q;
    case (st_q)
      qecc_pkg::ST_IDLE:   if (!empty_i) st_d = qecc_pkg::ST_MUL;
      qecc_pkg::ST_MUL:    if (idx_q == 5'd23 && ph_q == 2'd3) st_d = qecc_pkg::ST_DET;
      qecc_pkg::ST_DET:    st_d = det_ok ? qecc_pkg::ST_DIVSET : qecc_pkg::ST_OUT;
      qecc_pkg::ST_DIVSET: st_d = qecc_pkg::ST_DIV;
      qecc_pkg::ST_DIV:    if (bit_q == 8'd0) st_d = qecc_pkg::ST_DIVEND;
      qecc_pkg::ST_DIVEND: st_d = (ax_q == 2'd2) ? qecc_pkg::ST_COST : qecc_pkg::ST_DIVSET;
      qecc_pkg::ST_COST:   if (ci_q == 4'd15 && ph_q == 2'd3) st_d = qecc_pkg::ST_RND;
      qecc_pkg::ST_RND:    st_d = qecc_pkg::ST_OUT;
      qecc_pkg::ST_OUT:    if (out_ready) st_d = qecc_pkg::ST_IDLE;
      default:             st_d = qecc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= qecc_pkg::ST_IDLE;
    else         st_q <= st_d;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      qecc_pkg::ST_IDLE: begin
        qd_q <= quad_i;
        idx_q <= '0; ph_q <= '0; ax_q <= '0; ci_q <= '0;
        for (int k = 0; k < 4; k++) acc_q[k] <= '0;
        cost_q <= '0;
      end
      qecc_pkg::ST_MUL, qecc_pkg::ST_COST: begin
        case (ph_q)
          2'd0: begin p1_q <= m0; ph_q <= 2'd1; end
          2'd1: begin p2_q <= 99'(mlo); ph_q <= 2'd2; end
          2'd2: begin p2_q <= p2_q + (99'(mhi) <<< 33); ph_q <= 2'd3; end
          default: begin
            ph_q <= 2'd0;
            if (st_q == qecc_pkg::ST_COST) begin
              cost_q <= cost_q + 256'(p2_q);
              ci_q <= ci_q + 4'd1;
            end else begin
              acc_q[pe.dst] <= pe.neg ? acc_q[pe.dst] - 256'(p2_q)
                                      : acc_q[pe.dst] + 256'(p2_q);
              idx_q <= idx_q + 5'd1;
            end
          end
        endcase
      end
      qecc_pkg::ST_DIVSET: begin
        num_q <= acc_q[ax_q + 2'd1][qecc_pkg::WW-1] ?
                 256'(-(acc_q[ax_q + 2'd1] <<< 16)) : 256'(acc_q[ax_q + 2'd1] <<< 16);
        nneg_q <= acc_q[ax_q + 2'd1][qecc_pkg::WW-1];
        den_q <= acc_q[0];
        rem_q <= '0; quo_q <= '0; bit_q <= 8'd255;
      end
      qecc_pkg::ST_DIV: begin
        if (rem_sh >= den_q) begin
          rem_q <= rem_sh - den_q; quo_q[bit_q] <= 1'b1;
        end else rem_q <= rem_sh;
        bit_q <= bit_q - 8'd1;
      end
      qecc_pkg::ST_DIVEND: begin
        v_q[ax_q] <= sat_hi ? 32'sh7fffffff : sat_lo ? 32'sh80000000 : qs[31:0];
        ax_q <= ax_q + 2'd1;
      end
      default: ;
    endcase
  end

  // result register loaded on the way to the output state
  always_ff @(posedge clk_i) begin
    if (st_q == qecc_pkg::ST_DET && !det_ok) begin
      pos_x_o <= '0; pos_y_o <= '0; pos_z_o <= '0; cost_o <= '0; singular_o <= 1'b1;
    end else if (st_q == qecc_pkg::ST_RND) begin
      pos_x_o <= v_q[0]; pos_y_o <= v_q[1]; pos_z_o <= v_q[2];
      singular_o <= 1'b0;
      cost_o <= 64'(cost_sat);
    end
  end
  // saturated rounded cost, registered into cost_o in ST_RND after the last term
  always_comb begin
    if (!cost_r[qecc_pkg::WW-1] && cost_r[qecc_pkg::WW-1:63] != '0)
      cost_sat = 256'h7fffffffffffffff;
    else if (cost_r[qecc_pkg::WW-1] && cost_r[qecc_pkg::WW-1:63] != '1)
      cost_sat = {{192{1'b1}}, 64'h8000000000000000};
    else cost_sat = cost_r;
  end
endmodule
`default_nettype wire

// ===== src/quadric_edge_collapse_cost_top.sv =====
`default_nettype none
// channel  | dir | handshake            | payload
// input    | in  | in_valid / in_ready  | q00_i..q33_i, is_second_i
// result   | out | out_valid / out_ready| pos_x_o, pos_y_o, pos_z_o, cost_o, singular_o
// config   | in  | cfg_we               | cfg_wdata (threshold, 63 bit)
// A first-endpoint item is held in the front. A second-endpoint item is
// summed and queued; the back end computes the 24 triple products of the
// determinant and numerators, then runs the serial divider for each of the
// three axes and sums the 16 cost terms (a singular edge ends after the
// products). Reset clears control only; the two-entry queue lets the front
// keep taking items while the back end or the result waits.
module quadric_edge_collapse_cost_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we,
  input  wire logic [62:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] q00_i, q01_i, q02_i, q03_i, q11_i,
  input  wire logic signed [31:0] q12_i, q13_i, q22_i, q23_i, q33_i,
  input  wire logic               is_second_i,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o,
  output logic signed [63:0]      cost_o,
  output logic                    singular_o
);
  `include "quadric_edge_collapse_cost_top_assert.svh"

  logic [62:0] thr_q;
  qecc_pkg::entry_t q [10];
  qecc_pkg::quad_t  qin, qout;
  logic push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     thr_q <= 63'd1;
    else if (cfg_we) thr_q <= cfg_wdata;
  end

  assign q = '{q00_i, q01_i, q02_i, q03_i, q11_i, q12_i, q13_i, q22_i, q23_i, q33_i};

  qecc_front u_front (.clk_i, .in_valid, .in_ready, .q_i(q), .is_second_i,
                      .push_o(push), .quad_o(qin), .full_i(full));
  qecc_queue u_queue (.clk_i, .rst_ni, .push_i(push), .data_i(qin), .full_o(full),
                      .pop_i(pop), .empty_o(empty), .data_o(qout));
  qecc_back u_back (.clk_i, .rst_ni, .thr_i(thr_q), .empty_i(empty), .quad_i(qout),
                    .pop_o(pop), .out_valid, .out_ready, .pos_x_o, .pos_y_o, .pos_z_o,
                    .cost_o, .singular_o);

  // checks
  `QEC_ASSERT_IMP(a_no_push_full, full, !push)
  `QEC_ASSERT_IMP(a_no_pop_empty, empty, !pop)
  `QEC_ASSERT_IMP(a_sing_zero, out_valid && singular_o, cost_o == '0 && pos_x_o == '0)
  `QEC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cost_o))
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  typedef qecc_pkg::entry_t entry_t;

  typedef logic signed [255:0] w_t;

  // one input transaction plus an optional typed-in expectation
  typedef struct {
    entry_t             q[10];
    bit                 sec;
    bit                 typed;
    logic signed [31:0] ex, ey, ez;
    logic signed [63:0] ecost;
    bit                 esing;
  } edge_item_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic signed [63:0] cost;
    bit                 sing;
  } vertex_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [62:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  entry_t               q_drv[10];
  logic                 is_second_i = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [31:0]   pos_x_o, pos_y_o, pos_z_o;
  logic signed [63:0]   cost_o;
  logic                 singular_o;

  // predictor state
  entry_t               held_q[10];
  logic [62:0]          det_limit = 63'd1;
  vertex_t              pending_vertices[$];
  edge_item_t           directed_rows[$];
  int unsigned          n_errors = 0;
  int unsigned          n_results = 0;
  int unsigned          n_singular = 0;
  int unsigned          n_items = 0;
  int unsigned          stall_left = 0;
  bit                   rx_calm = 1'b0;
  bit                   tx_calm = 1'b0;

  initial for (int k = 0; k < 10; k++) q_drv[k] = '0;

  quadric_edge_collapse_cost_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q00_i      (q_drv[0]),
    .q01_i      (q_drv[1]),
    .q02_i      (q_drv[2]),
    .q03_i      (q_drv[3]),
    .q11_i      (q_drv[4]),
    .q12_i      (q_drv[5]),
    .q13_i      (q_drv[6]),
    .q22_i      (q_drv[7]),
    .q23_i      (q_drv[8]),
    .q33_i      (q_drv[9]),
    .is_second_i(is_second_i),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .cost_o     (cost_o),
    .singular_o (singular_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(w_t v);
    if (v > w_t'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -w_t'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] clamp64(w_t v);
    w_t top;
    top = w_t'({1'b0, {63{1'b1}}});
    if (v > top) return {1'b0, {63{1'b1}}};
    if (v < -top - 1) return {1'b1, 63'd0};
    return v[63:0];
  endfunction

  // optimal vertex and its error for the held quadric plus the incoming one
  function automatic vertex_t collapse_vertex(entry_t qi[10]);
    int      rr[10] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    int      cc[10] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
    w_t      a[4][4];
    w_t      det, n0, n1, n2, acc;
    w_t      v[4];
    vertex_t r;
    for (int k = 0; k < 10; k++) begin
      a[rr[k]][cc[k]] = w_t'(held_q[k]) + w_t'(qi[k]);
      a[cc[k]][rr[k]] = a[rr[k]][cc[k]];
    end
    r = '{default: '0};
    det = a[0][0]*a[1][1]*a[2][2] - a[0][2]*a[0][2]*a[1][1]
        + 2*a[0][1]*a[0][2]*a[1][2] - a[0][0]*a[1][2]*a[1][2]
        - a[0][1]*a[0][1]*a[2][2];
    if (!(det > w_t'({1'b0, det_limit}))) begin
      r.sing = 1'b1;
      return r;
    end
    n0 = a[0][1]*a[1][3]*a[2][2] - a[0][2]*a[1][2]*a[1][3] + a[0][3]*a[1][2]*a[1][2]
       - a[0][3]*a[1][1]*a[2][2] + a[0][2]*a[1][1]*a[2][3] - a[0][1]*a[1][2]*a[2][3];
    n1 = a[0][2]*a[0][2]*a[1][3] + a[0][1]*a[0][3]*a[2][2] - a[0][0]*a[1][3]*a[2][2]
       + a[0][0]*a[1][2]*a[2][3] - a[0][2]*a[0][3]*a[1][2] - a[0][2]*a[0][1]*a[2][3];
    n2 = a[0][2]*a[0][3]*a[1][1] - a[0][1]*a[0][3]*a[1][2] - a[0][1]*a[0][2]*a[1][3]
       + a[0][0]*a[1][2]*a[1][3] + a[0][1]*a[0][1]*a[2][3] - a[0][0]*a[1][1]*a[2][3];
    r.x = clamp32((n0 * 65536) / det);
    r.y = clamp32((n1 * 65536) / det);
    r.z = clamp32((n2 * 65536) / det);
    v[0] = w_t'(r.x);
    v[1] = w_t'(r.y);
    v[2] = w_t'(r.z);
    v[3] = 65536;
    acc = '0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        acc += a[i][j] * v[i] * v[j];
    r.cost = clamp64((acc + 32768) >>> 16);
    return r;
  endfunction

  function automatic edge_item_t diag_item(entry_t d, entry_t b, entry_t c, bit sec);
    edge_item_t it;
    it = '{default: '0};
    foreach (it.q[k]) it.q[k] = '0;
    it.q[0] = d;
    it.q[4] = d;
    it.q[7] = d;
    it.q[3] = b;
    it.q[9] = c;
    it.sec = sec;
    return it;
  endfunction

  function automatic edge_item_t fill_item(entry_t val, bit sec);
    edge_item_t it;
    it = '{default: '0};
    foreach (it.q[k]) it.q[k] = val;
    it.sec = sec;
    return it;
  endfunction

  function automatic edge_item_t typed(edge_item_t it, bit sing, logic signed [63:0] c);
    it.typed = 1'b1;
    it.esing = sing;
    it.ecost = c;
    it.ex = '0;
    it.ey = '0;
    it.ez = '0;
    return it;
  endfunction

  function automatic entry_t srand(int unsigned m);
    return $signed($urandom_range(0, 2 * m)) - $signed(m);
  endfunction

  // random quadric: mostly well conditioned, some full-range or small noise
  function automatic edge_item_t rand_item(bit sec);
    edge_item_t  it;
    int unsigned kind;
    it = '{default: '0};
    kind = $urandom_range(0, 9);
    foreach (it.q[k]) begin
      if (kind < 2) it.q[k] = $urandom;
      else if (kind < 3) it.q[k] = srand(1 << 18);
      else it.q[k] = srand(1 << 12);
    end
    if (kind >= 3) begin
      it.q[0] = $urandom_range(1 << 14, 1 << 22);
      it.q[4] = $urandom_range(1 << 14, 1 << 22);
      it.q[7] = $urandom_range(1 << 14, 1 << 22);
      it.q[3] = srand(1 << 22);
      it.q[6] = srand(1 << 22);
      it.q[8] = srand(1 << 22);
      it.q[9] = $urandom_range(0, 1 << 26);
    end
    it.sec = sec;
    return it;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 200);
  endfunction

  // drive one transaction, predict on acceptance, then idle a while
  task automatic send_item(edge_item_t it);
    int unsigned gap;
    vertex_t     e;
    in_valid <= 1'b1;
    is_second_i <= it.sec;
    foreach (it.q[k]) q_drv[k] <= it.q[k];
    do @(posedge clk_i); while (!in_ready);
    n_items++;
    if (it.sec) begin
      if (it.typed) begin
        e.x = it.ex;
        e.y = it.ey;
        e.z = it.ez;
        e.cost = it.ecost;
        e.sing = it.esing;
      end else begin
        e = collapse_vertex(it.q);
      end
      pending_vertices.push_back(e);
    end else begin
      foreach (it.q[k]) held_q[k] = it.q[k];
    end
    gap = tx_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic set_det_limit(logic [62:0] val);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    det_limit = val;
  endtask

  // result side: random backpressure with calm stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 4095) == 0) rx_calm <= ~rx_calm;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && out_valid && out_ready) begin
      n_results++;
      if (pending_vertices.size() == 0) begin
        $error("result with no expectation pending");
        n_errors++;
      end else begin
        e = pending_vertices.pop_front();
        if (e.sing) n_singular++;
        if (pos_x_o !== e.x) begin
          $error("pos_x: expected %0d, got %0d", e.x, pos_x_o);
          n_errors++;
        end
        if (pos_y_o !== e.y) begin
          $error("pos_y: expected %0d, got %0d", e.y, pos_y_o);
          n_errors++;
        end
        if (pos_z_o !== e.z) begin
          $error("pos_z: expected %0d, got %0d", e.z, pos_z_o);
          n_errors++;
        end
        if (cost_o !== e.cost) begin
          $error("cost: expected %0d, got %0d", e.cost, cost_o);
          n_errors++;
        end
        if (singular_o !== e.sing) begin
          $error("singular: expected %0b, got %0b", e.sing, singular_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    edge_item_t  it;
    logic [62:0] limits[5];
    int unsigned r, waited;
    limits[0] = 63'd0;
    limits[1] = 63'd1 << 48;
    limits[2] = 63'({$urandom, $urandom} >> 1);
    limits[3] = {63{1'b1}};
    limits[4] = 63'd1;

    // directed stimulus
    directed_rows.push_back(fill_item(32'sd0, 1'b0));
    directed_rows.push_back(typed(fill_item(32'sd0, 1'b1), 1'b1, 64'sd0));
    directed_rows.push_back(fill_item(32'sh7fffffff, 1'b0));
    directed_rows.push_back(typed(fill_item(32'sh7fffffff, 1'b1), 1'b1, 64'sd0));
    directed_rows.push_back(fill_item(32'sh80000000, 1'b0));
    directed_rows.push_back(typed(fill_item(32'sh80000000, 1'b1), 1'b1, 64'sd0));
    // unit matrix, vertex at origin, error 1.0; held quadric survives a result
    directed_rows.push_back(diag_item(32'sd65536, 32'sd0, 32'sd65536, 1'b0));
    directed_rows.push_back(typed(fill_item(32'sd0, 1'b1), 1'b0, 64'sh1_0000_0000));
    directed_rows.push_back(typed(fill_item(32'sd0, 1'b1), 1'b0, 64'sh1_0000_0000));
    // negative determinant
    directed_rows.push_back(diag_item(-32'sd65536, 32'sd0, 32'sd0, 1'b0));
    directed_rows.push_back(typed(fill_item(32'sd0, 1'b1), 1'b1, 64'sd0));
    // determinant exactly at the threshold
    directed_rows.push_back(diag_item(32'sd1, 32'sd5, 32'sd0, 1'b0));
    directed_rows.push_back(typed(fill_item(32'sd0, 1'b1), 1'b1, 64'sd0));
    directed_rows.push_back(diag_item(32'sd65536, -32'sd65536, 32'sd0, 1'b0));
    directed_rows.push_back(fill_item(32'sd0, 1'b1));
    // tiny determinant with huge offsets: positions saturate
    it = diag_item(32'sd2, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    it.q[6] = 32'sh80000000;
    it.q[8] = 32'sd12345;
    directed_rows.push_back(it);
    directed_rows.push_back(fill_item(32'sd0, 1'b1));
    directed_rows.push_back(fill_item(32'sh55555555, 1'b0));
    directed_rows.push_back(fill_item(32'shaaaaaaaa, 1'b1));
    directed_rows.push_back(rand_item(1'b0));
    directed_rows.push_back(rand_item(1'b1));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // random phases, one threshold each
    foreach (limits[p]) begin
      set_det_limit(limits[p]);
      send_item(rand_item(1'b0));
      for (int n = 0; n < 275; n++) begin
        if (n % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 8) send_item(rand_item(1'b1));
        else if (r < 16) send_item(rand_item(1'b0));
        else begin
          send_item(rand_item(1'b0));
          send_item(rand_item(1'b1));
          n++;
        end
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_vertices.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (1000) @(posedge clk_i);
    if (pending_vertices.size() != 0) begin
      $error("%0d expected results never arrived", pending_vertices.size());
      n_errors++;
    end
    $display("ran %0d quadric transactions over 6 threshold settings", n_items);
    $display("checked %0d collapse results, %0d of them singular", n_results, n_singular);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
